// ----- rtl/bba_pkg.sv -----
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Shared widths, constants, result codes and the lowest-clear-bit function.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

    localparam int BLOCK_W      = 13;
    localparam int COUNT_W      = 14;
    localparam int BLOCK_CAP    = 8192;
    localparam int USABLE_RESET = 7931;

    localparam logic [7:0] FULL_BYTE = 8'hFF;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_NO_FREE      = 2'd1,
        ST_RANGE        = 2'd2,
        ST_ALREADY_FREE = 2'd3
    } status_t;

    // Position of the lowest clear bit; seven when only the top bit is clear or none is.
    function automatic logic [2:0] lowest_zero(input logic [7:0] byte_val);
        logic [2:0] pos;
        pos = 3'd7;
        for (int i = 6; i >= 0; i--)
        begin
            if (!byte_val[i])
            begin
                pos = 3'(i);
            end
        end
        return pos;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/bba_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/bitmap_block_allocator.sv -----
// ----------------------------------------------------------------------------
// Bitmap block allocator
// First-fit allocator over a one-bit-per-block occupancy map held in RAM.
// ----------------------------------------------------------------------------
//   Channel   Signals                                   Direction
//   in        in_valid/in_ready, command, block_index   into the block
//   out       out_valid/out_ready, block_number,        out of the block
//             status, free_count
//   cfg       cfg_we, cfg_wdata (usable_blocks)         into the block
//
// A free checks its map byte in S_FREE and then goes to S_RESULT. An allocate
// scans from the first byte in S_SCAN up to the first byte that is not full or
// the last byte; the map RAM is read one byte a cycle during the scan. A free
// past the limit and an allocate with a zero count go straight to S_RESULT.
// One word is in work at a time; a new word is taken while the last result
// waits on out. A result waits in its final state while out is stalled.
// After reset the map reads as clear through a fill mark, so no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_block_allocator
    import bba_pkg::*;
#(
    parameter int MAP_BYTES = 1024
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               command,
    input  wire logic [BLOCK_W-1:0] block_index,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic      [BLOCK_W-1:0] block_number,
    output logic      [1:0]         status,
    output logic      [COUNT_W-1:0] free_count,
    input  wire logic               cfg_we,
    input  wire logic [COUNT_W-1:0] cfg_wdata
);

    localparam int AW          = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int HW          = $clog2(MAP_BYTES + 1);
    localparam int LIM_CAP     = (MAP_BYTES * 8 < BLOCK_CAP) ? MAP_BYTES * 8 : BLOCK_CAP;
    localparam int FREE_RESET  = (USABLE_RESET < LIM_CAP) ? USABLE_RESET : LIM_CAP;

    localparam logic [AW-1:0]      LAST_ADDR = AW'(MAP_BYTES - 1);
    localparam logic [COUNT_W-1:0] CAP_VAL   = COUNT_W'(LIM_CAP);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FREE,
        S_SCAN,
        S_RESULT
    } state_t;

    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] usable_reg, usable_next;
    logic [COUNT_W-1:0] free_reg, free_next;
    logic [HW-1:0]      hwm_reg, hwm_next;
    logic [AW-1:0]      rd_addr_reg;
    logic               cmd_reg, cmd_next;
    logic [2:0]         bit_reg, bit_next;
    logic [BLOCK_W-1:0] res_number_reg, res_number_next;
    status_t            res_status_reg, res_status_next;
    logic               wr_en_reg, wr_en_next;
    logic [AW-1:0]      wr_addr_reg, wr_addr_next;
    logic [7:0]         wr_data_reg, wr_data_next;
    logic               out_valid_reg, out_valid_next;
    logic [BLOCK_W-1:0] out_number_reg, out_number_next;
    status_t            out_status_reg, out_status_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;

    logic [COUNT_W-1:0] lim;
    logic [AW-1:0]      ram_raddr;
    logic [7:0]         ram_rdata;
    logic [7:0]         rd_byte;
    logic               ram_we;
    logic [2:0]         zero_pos;
    logic [31:0]        alloc_bit;
    logic               slot_free;

    assign lim       = (usable_reg > CAP_VAL) ? CAP_VAL : usable_reg;
    assign rd_byte   = (HW'(rd_addr_reg) < hwm_reg) ? ram_rdata : 8'h00;
    assign zero_pos  = lowest_zero(rd_byte);
    assign alloc_bit = 32'({rd_addr_reg, zero_pos});
    assign slot_free = !out_valid_reg || out_ready;
    assign ram_we    = (state_reg == S_RESULT) && slot_free && wr_en_reg;

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign block_number = out_number_reg;
    assign status       = out_status_reg;
    assign free_count   = out_count_reg;

    bba_ram #(
        .WIDTH (8),
        .DEPTH (MAP_BYTES)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_addr_reg),
        .wdata (wr_data_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        usable_next     = usable_reg;
        free_next       = free_reg;
        hwm_next        = hwm_reg;
        cmd_next        = cmd_reg;
        bit_next        = bit_reg;
        res_number_next = res_number_reg;
        res_status_next = res_status_reg;
        wr_en_next      = wr_en_reg;
        wr_addr_next    = wr_addr_reg;
        wr_data_next    = wr_data_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_number_next = out_number_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        ram_raddr       = AW'(32'(rd_addr_reg) + 32'd1);

        case (state_reg)
            S_IDLE:
            begin
                ram_raddr = '0;
                if (in_valid)
                begin
                    cmd_next   = command;
                    bit_next   = block_index[2:0];
                    wr_en_next = 1'b0;
                    if (command == CMD_FREE)
                    begin
                        res_number_next = block_index;
                        ram_raddr       = AW'(32'(block_index) >> 3);
                        if (COUNT_W'(block_index) >= lim)
                        begin
                            res_status_next = ST_RANGE;
                            state_next      = S_RESULT;
                        end
                        else
                        begin
                            state_next = S_FREE;
                        end
                    end
                    else
                    begin
                        res_number_next = '0;
                        if (free_reg == '0)
                        begin
                            res_status_next = ST_NO_FREE;
                            state_next      = S_RESULT;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                end
            end
            S_FREE:
            begin
                if (!rd_byte[bit_reg])
                begin
                    res_status_next = ST_ALREADY_FREE;
                end
                else
                begin
                    res_status_next = ST_OK;
                    wr_en_next      = 1'b1;
                    wr_addr_next    = rd_addr_reg;
                    wr_data_next    = rd_byte & ~(8'd1 << bit_reg);
                end
                state_next = S_RESULT;
            end
            S_SCAN:
            begin
                if (rd_byte != FULL_BYTE)
                begin
                    if (alloc_bit < 32'(lim))
                    begin
                        res_status_next = ST_OK;
                        res_number_next = BLOCK_W'(alloc_bit);
                        wr_en_next      = 1'b1;
                        wr_addr_next    = rd_addr_reg;
                        wr_data_next    = rd_byte | (8'd1 << zero_pos);
                    end
                    else
                    begin
                        res_status_next = ST_NO_FREE;
                    end
                    state_next = S_RESULT;
                end
                else if (rd_addr_reg == LAST_ADDR)
                begin
                    res_status_next = ST_NO_FREE;
                    state_next      = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (slot_free)
                begin
                    if (res_status_reg == ST_OK)
                    begin
                        if (cmd_reg == CMD_ALLOC)
                        begin
                            free_next = free_reg - COUNT_W'(1);
                        end
                        else if (free_reg < lim)
                        begin
                            free_next = free_reg + COUNT_W'(1);
                        end
                    end
                    if (wr_en_reg && (HW'(wr_addr_reg) >= hwm_reg))
                    begin
                        hwm_next = HW'(32'(wr_addr_reg) + 32'd1);
                    end
                    out_valid_next  = 1'b1;
                    out_number_next = res_number_reg;
                    out_status_next = res_status_reg;
                    out_count_next  = free_next;
                    wr_en_next      = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            usable_next = cfg_wdata;
            free_next   = (cfg_wdata > CAP_VAL) ? CAP_VAL : cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            usable_reg     <= COUNT_W'(USABLE_RESET);
            free_reg       <= COUNT_W'(FREE_RESET);
            hwm_reg        <= '0;
            wr_en_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_number_reg <= '0;
            out_status_reg <= ST_OK;
            out_count_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            usable_reg     <= usable_next;
            free_reg       <= free_next;
            hwm_reg        <= hwm_next;
            wr_en_reg      <= wr_en_next;
            out_valid_reg  <= out_valid_next;
            out_number_reg <= out_number_next;
            out_status_reg <= out_status_next;
            out_count_reg  <= out_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg    <= ram_raddr;
        cmd_reg        <= cmd_next;
        bit_reg        <= bit_next;
        res_number_reg <= res_number_next;
        res_status_reg <= res_status_next;
        wr_addr_reg    <= wr_addr_next;
        wr_data_reg    <= wr_data_next;
    end

    // The free count never exceeds the effective limit.
    assert property (@(posedge clk) disable iff (!rst_n) free_reg <= lim)
        else $error("free count above limit");

    // The fill mark never runs past the end of the map.
    assert property (@(posedge clk) disable iff (!rst_n) hwm_reg <= HW'(MAP_BYTES))
        else $error("fill mark beyond map");

    // A new result is only loaded from the result state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_RESULT))
        else $error("result loaded outside result state");

    // A successful word always names a block below the limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == ST_OK) |-> (COUNT_W'(out_number_reg) < lim))
        else $error("successful result beyond limit");

    // The map is written only when the write decision was taken beforehand.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ($past(state_reg == S_FREE) || $past(state_reg == S_SCAN)
                    || $past(state_reg == S_RESULT)))
        else $error("map write without a decision");

endmodule

`default_nettype wire

// ----- tb/bitmap_block_allocator_checker.sv -----
// ----------------------------------------------------------------------------
// Bitmap block allocator checker
// Watches the command, result and register ports of the allocator. It keeps
// its own occupancy map, free count and block limit, works out the result of
// every accepted command word and compares each accepted result word with the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_checker
    import bba_pkg::*;
#(
    parameter int MAP_BYTES = 1024
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire logic               command,
    input  wire logic [BLOCK_W-1:0] block_index,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire logic [BLOCK_W-1:0] block_number,
    input  wire logic [1:0]         status,
    input  wire logic [COUNT_W-1:0] free_count,
    input  wire logic               cfg_we,
    input  wire logic [COUNT_W-1:0] cfg_wdata,
    output int                      pending_words,
    output int                      failures
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [BLOCK_W-1:0] block_number;
        status_t            status;
        logic [COUNT_W-1:0] free_count;
    } alloc_result_t;

    logic [7:0]         occupancy [MAP_BYTES];
    logic [COUNT_W-1:0] usable_blocks;
    logic [COUNT_W-1:0] blocks_free;
    alloc_result_t      awaited_results [$];
    int                 fail_tally = 0;

    initial
    begin
        pending_words = 0;
        failures = 0;
    end

    function automatic int block_limit();
        int lim;
        lim = usable_blocks;
        if (lim > BLOCK_CAP)
            lim = BLOCK_CAP;
        if (lim > MAP_BYTES * 8)
            lim = MAP_BYTES * 8;
        return lim;
    endfunction

    function automatic alloc_result_t run_command(input logic cmd,
                                                  input logic [BLOCK_W-1:0] idx);
        alloc_result_t res;
        int            lim;
        int            k;
        int            b;
        logic [7:0]    byte_val;
        lim = block_limit();
        res.block_number = '0;
        res.status = ST_NO_FREE;
        if (cmd == CMD_ALLOC)
        begin
            if (blocks_free != 0)
            begin
                k = 0;
                while (k < MAP_BYTES && occupancy[k] == FULL_BYTE)
                    k++;
                if (k < MAP_BYTES)
                begin
                    byte_val = occupancy[k];
                    b = 0;
                    while (b < 7 && byte_val[b])
                        b++;
                    if (k * 8 + b < lim)
                    begin
                        occupancy[k][b] = 1'b1;
                        blocks_free = blocks_free - 1'b1;
                        res.block_number = BLOCK_W'(k * 8 + b);
                        res.status = ST_OK;
                    end
                end
            end
        end
        else
        begin
            res.block_number = idx;
            if (idx >= lim)
                res.status = ST_RANGE;
            else if (!occupancy[idx >> 3][idx[2:0]])
                res.status = ST_ALREADY_FREE;
            else
            begin
                occupancy[idx >> 3][idx[2:0]] = 1'b0;
                if (blocks_free < lim)
                    blocks_free = blocks_free + 1'b1;
                res.status = ST_OK;
            end
        end
        res.free_count = blocks_free;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        alloc_result_t want;
        if (!rst_n)
        begin
            foreach (occupancy[i])
                occupancy[i] = '0;
            usable_blocks = COUNT_W'(USABLE_RESET);
            blocks_free = COUNT_W'(block_limit());
            awaited_results.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("unexpected result word: block_number %0d, status %0d",
                           block_number, status);
                    fail_tally++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (block_number !== want.block_number)
                    begin
                        $error("block_number: expected %0d, got %0d",
                               want.block_number, block_number);
                        fail_tally++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        fail_tally++;
                    end
                    if (free_count !== want.free_count)
                    begin
                        $error("free_count: expected %0d, got %0d",
                               want.free_count, free_count);
                        fail_tally++;
                    end
                end
            end
            if (cfg_we)
            begin
                usable_blocks = cfg_wdata;
                blocks_free = COUNT_W'(block_limit());
            end
            if (in_valid && in_ready)
                awaited_results.push_back(run_command(command, block_index));
        end
        pending_words <= awaited_results.size();
        failures <= fail_tally;
    end

endmodule

// ----- tb/bitmap_block_allocator_test.sv -----
// ----------------------------------------------------------------------------
// Bitmap block allocator test
// Drives allocate and free words into the allocator, first a directed set
// around the limits and the error cases, then random words over several block
// limits with idle and stall patterns on both sides. The checker beside the
// block predicts and compares every result word.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bba_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               command = CMD_ALLOC;
    logic [BLOCK_W-1:0] block_index = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [BLOCK_W-1:0] block_number;
    logic [1:0]         status;
    logic [COUNT_W-1:0] free_count;
    logic               cfg_we = 1'b0;
    logic [COUNT_W-1:0] cfg_wdata = '0;
    int                 pending_words;
    int                 failures;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hot_span = 96;
    int idle_plan [4][2] = '{'{0, 0}, '{48, 0}, '{0, 48}, '{17, 17}};
    int phase_limits [6] = '{8192, 40, 3, 7931, 1000, 16383};

    bitmap_block_allocator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .block_index  (block_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .block_number (block_number),
        .status       (status),
        .free_count   (free_count),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    bitmap_block_allocator_checker audit (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .block_index   (block_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .block_number  (block_number),
        .status        (status),
        .free_count    (free_count),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .pending_words (pending_words),
        .failures      (failures)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    task automatic send_word(input logic cmd, input logic [BLOCK_W-1:0] idx);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        block_index <= idx;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_words != 0)
            @(posedge clk);
    endtask

    task automatic write_limit(input logic [COUNT_W-1:0] value);
        settle();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_word();
        int                 pick;
        logic [BLOCK_W-1:0] idx;
        pick = $urandom_range(0, 99);
        idx = BLOCK_W'($urandom);
        if (pick < 50)
            send_word(CMD_ALLOC, idx);
        else if (pick < 90)
            send_word(CMD_FREE, BLOCK_W'($urandom_range(0, hot_span)));
        else
            send_word(CMD_FREE, idx);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(CMD_FREE, 13'd0);
        send_word(CMD_FREE, 13'd8191);
        send_word(CMD_FREE, 13'd7931);
        send_word(CMD_FREE, 13'd7930);
        send_word(CMD_ALLOC, 13'd8191);
        send_word(CMD_ALLOC, 13'd0);
        send_word(CMD_FREE, 13'd0);
        send_word(CMD_FREE, 13'd0);
        send_word(CMD_ALLOC, 13'd0);

        write_limit(14'd0);
        send_word(CMD_ALLOC, 13'd0);
        send_word(CMD_FREE, 13'd1);

        write_limit(14'd1);
        send_word(CMD_ALLOC, 13'd0);
        send_word(CMD_FREE, 13'd1);
        send_word(CMD_FREE, 13'd0);
        send_word(CMD_ALLOC, 13'd0);
        send_word(CMD_ALLOC, 13'd0);

        write_limit(14'd16383);
        send_word(CMD_FREE, 13'd8191);
        send_word(CMD_ALLOC, 13'd0);
        send_word(CMD_FREE, 13'd1);
        send_word(CMD_ALLOC, 13'h1555);

        foreach (phase_limits[p])
        begin
            write_limit(COUNT_W'(phase_limits[p]));
            hot_span = (phase_limits[p] < 96) ? phase_limits[p] : 96;
            send_idle_pct = idle_plan[p % 4][0];
            recv_stall_pct = idle_plan[p % 4][1];
            repeat (80) random_word();
        end

        settle();
        repeat (1100) @(posedge clk);
        if (failures == 0)
            $display("bitmap_block_allocator verification clean");
        else
            $display("bitmap_block_allocator verification failed");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("bitmap_block_allocator verification failed");
        $finish;
    end

endmodule
